// ===== rtl/assert_macros.svh =====
// assertion helpers included by byte_dma_channel_registers_unit
// each macro expects clk and rst to be visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// consequent must hold on the edge after the antecedent
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: expected follow-up missing");

// consequent must hold on the same edge as the antecedent
`define ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: implication violated");

`endif

// ===== rtl/bdcr_pkg.sv =====
`default_nettype none

package bdcr_pkg;

  // register slots inside one channel
  localparam int SPECIAL_SLOTS = 10;
  localparam logic [3:0] SLOT_CTRL    = 4'd0;
  localparam logic [3:0] SLOT_STATUS  = 4'd1;
  localparam logic [3:0] SLOT_CONFIG  = 4'd2;
  localparam logic [3:0] SLOT_MISC    = 4'd3;
  localparam logic [3:0] SLOT_SRC_LO  = 4'd4;
  localparam logic [3:0] SLOT_SRC_HI  = 4'd5;
  localparam logic [3:0] SLOT_DST_LO  = 4'd6;
  localparam logic [3:0] SLOT_DST_HI  = 4'd7;
  localparam logic [3:0] SLOT_SIZE_LO = 4'd8;
  localparam logic [3:0] SLOT_SIZE_HI = 4'd9;

  // access modes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // control and status bits
  localparam logic [15:0] CTRL_KEEP   = 16'hfffe;
  localparam logic [15:0] ST_BUSY     = 16'h0002;
  localparam logic [15:0] ST_SET      = 16'h001c;
  localparam logic [15:0] ST_W1C_MASK = 16'h001f;

  // port codes and memory select
  localparam logic [3:0] PORT_MEM0  = 4'h0;
  localparam logic [3:0] PORT_MEM1  = 4'h1;
  localparam logic [3:0] PORT_FLASH = 4'h5;
  localparam logic [1:0] SEL_SRAM   = 2'h2;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRAM_BASE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRAM_BASE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_BASE = 2'd2;

  // one channel's dedicated register row
  typedef logic [SPECIAL_SLOTS-1:0][15:0] bdcr_row_t;

  // address translation bases
  typedef struct packed {
    logic [31:0] dram;
    logic [31:0] sram;
    logic [31:0] flash;
  } bdcr_bases_t;

  // translation result
  typedef struct packed {
    logic        ok;
    logic [31:0] phys;
  } bdcr_map_t;

  // one bus access
  typedef struct packed {
    logic        mode;
    logic        channel;
    logic [3:0]  reg_index;
    logic [15:0] write_data;
  } bdcr_item_t;

  // one result
  typedef struct packed {
    logic [15:0] read_data;
    logic        copy_start;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic [31:0] copy_bytes;
    logic        bad_port;
  } bdcr_result_t;

endpackage

`default_nettype wire

// ===== rtl/bdcr_in_if.sv =====
`default_nettype none

// bus access channel
interface bdcr_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        channel;
  logic [3:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, output mode, output channel, output reg_index,
                  output write_data, input ready);
  modport sink (input valid, input mode, input channel, input reg_index,
                input write_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdcr_out_if.sv =====
`default_nettype none

// result channel
interface bdcr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        copy_start;
  logic [31:0] copy_source;
  logic [31:0] copy_dest;
  logic [31:0] copy_bytes;
  logic        bad_port;

  modport source (output valid, output read_data, output copy_start,
                  output copy_source, output copy_dest, output copy_bytes,
                  output bad_port, input ready);
  modport sink (input valid, input read_data, input copy_start,
                input copy_source, input copy_dest, input copy_bytes,
                input bad_port, output ready);
endinterface

`default_nettype wire

// ===== rtl/bdcr_port_map.sv =====
`default_nettype none

// translates a channel port and address into a physical address
module bdcr_port_map #(
  parameter int FLASH_WINDOW_LOG2 = 24
) (
  input  wire logic [3:0]          port,
  input  wire logic [1:0]          sel,
  input  wire logic [31:0]         addr,
  input  wire bdcr_pkg::bdcr_bases_t bases,
  output bdcr_pkg::bdcr_map_t      map
);

  localparam logic [31:0] FLASH_MASK = 32'((64'd1 << FLASH_WINDOW_LOG2) - 64'd1);

  logic [31:0] mem_base;

  // memory ports pick dram or sram by the misc select field
  assign mem_base = (sel == bdcr_pkg::SEL_SRAM) ? bases.sram : bases.dram;

  always_comb begin
    map.ok   = 1'b0;
    map.phys = '0;
    case (port)
      bdcr_pkg::PORT_MEM0, bdcr_pkg::PORT_MEM1: begin
        map.ok   = 1'b1;
        map.phys = mem_base + addr;
      end
      bdcr_pkg::PORT_FLASH: begin
        map.ok   = 1'b1;
        map.phys = bases.flash + (addr & FLASH_MASK);
      end
      default: begin
        map.ok   = 1'b0;
        map.phys = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/byte_dma_channel_registers_unit.sv =====
// Register front end of a two-channel byte DMA engine. Each transfer on the
// access channel is one read or write of a 16-bit channel register; each
// produces exactly one transfer on the result channel. Writing the control
// register with bit 0 set translates the source and destination ports and
// emits a copy command, setting the done, interrupt and result status bits;
// an unknown port raises bad_port and leaves status alone. Status is
// write-one-to-clear. An access is taken every cycle while the result is not
// stalled, passing through the input register and then the result register;
// the rate is set by the read-modify-write of the addressed channel's register
// row between those two registers. A stalled result holds the pipeline.
// The user must write base registers through cfg_write/cfg_index/cfg_data only
// while no access is in flight; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module byte_dma_channel_registers_unit #(
  parameter int CHANNELS          = 2,
  parameter int REGS_PER_CHANNEL  = 16,
  parameter int FLASH_WINDOW_LOG2 = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [bdcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data,
  bdcr_in_if.sink                               access,
  bdcr_out_if.source                            result
);

  // only channels and slots reachable through the access fields are stored
  localparam int EFF_CH      = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int EFF_REGS    = (REGS_PER_CHANNEL < 16) ? REGS_PER_CHANNEL : 16;
  localparam int PLAIN_N     = EFF_REGS - bdcr_pkg::SPECIAL_SLOTS;
  localparam int PLAIN_DEPTH = (PLAIN_N > 0) ? PLAIN_N : 1;
  localparam int PIDX_W      = (PLAIN_DEPTH > 1) ? $clog2(PLAIN_DEPTH) : 1;

  // base registers
  bdcr_pkg::bdcr_bases_t bases;

  // channel register storage
  bdcr_pkg::bdcr_row_t special [EFF_CH];
  logic [15:0]         plain [EFF_CH][PLAIN_DEPTH];

  // input register
  logic                 s1_valid;
  bdcr_pkg::bdcr_item_t s1;

  // result register
  logic                   out_valid;
  bdcr_pkg::bdcr_result_t res;
  bdcr_pkg::bdcr_result_t res_next;

  logic                adv;
  logic                ch_ok;
  logic                slot_ok;
  logic                in_range;
  logic                is_write;
  logic                is_plain;
  logic                ch_idx;
  logic [3:0]          poff;
  logic [PIDX_W-1:0]   pidx;
  bdcr_pkg::bdcr_row_t row;
  bdcr_pkg::bdcr_row_t row_next;
  logic                trigger;
  logic                start;
  bdcr_pkg::bdcr_map_t src_map;
  bdcr_pkg::bdcr_map_t dst_map;

  // pipeline moves when the result register is free or being drained
  assign adv          = s1_valid && (!out_valid || result.ready);
  assign access.ready = !s1_valid || adv;

  // base register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bases <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bdcr_pkg::CFG_DRAM_BASE:  bases.dram  <= cfg_data;
        bdcr_pkg::CFG_SRAM_BASE:  bases.sram  <= cfg_data;
        bdcr_pkg::CFG_FLASH_BASE: bases.flash <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (access.valid && access.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      s1.mode       <= access.mode;
      s1.channel    <= access.channel;
      s1.reg_index  <= access.reg_index;
      s1.write_data <= access.write_data;
    end
  end

  // address decode
  assign ch_ok    = (32'(s1.channel) < CHANNELS);
  assign slot_ok  = (32'(s1.reg_index) < REGS_PER_CHANNEL);
  assign in_range = ch_ok && slot_ok;
  assign is_write = (s1.mode == bdcr_pkg::MODE_WRITE);
  assign is_plain = (32'(s1.reg_index) >= bdcr_pkg::SPECIAL_SLOTS);
  assign ch_idx   = s1.channel & ch_ok;
  assign poff     = s1.reg_index - 4'(bdcr_pkg::SPECIAL_SLOTS);
  assign pidx     = poff[PIDX_W-1:0];
  assign row      = special[ch_idx];

  // port translation for source and destination
  bdcr_port_map #(.FLASH_WINDOW_LOG2(FLASH_WINDOW_LOG2)) u_src_map (
    .port  (row[bdcr_pkg::SLOT_CONFIG][3:0]),
    .sel   (row[bdcr_pkg::SLOT_MISC][13:12]),
    .addr  ({row[bdcr_pkg::SLOT_SRC_HI], row[bdcr_pkg::SLOT_SRC_LO]}),
    .bases (bases),
    .map   (src_map)
  );

  bdcr_port_map #(.FLASH_WINDOW_LOG2(FLASH_WINDOW_LOG2)) u_dst_map (
    .port  (row[bdcr_pkg::SLOT_CONFIG][11:8]),
    .sel   (row[bdcr_pkg::SLOT_MISC][13:12]),
    .addr  ({row[bdcr_pkg::SLOT_DST_HI], row[bdcr_pkg::SLOT_DST_LO]}),
    .bases (bases),
    .map   (dst_map)
  );

  assign trigger = in_range && is_write && (s1.reg_index == bdcr_pkg::SLOT_CTRL) &&
                   s1.write_data[0];
  assign start   = trigger && src_map.ok && dst_map.ok;

  // register row update and result
  always_comb begin
    row_next = row;
    res_next = '0;
    if (in_range && !is_write) begin
      res_next.read_data = is_plain ? plain[ch_idx][pidx] : row[s1.reg_index];
    end
    if (in_range && is_write) begin
      case (s1.reg_index)
        bdcr_pkg::SLOT_CTRL: begin
          row_next[bdcr_pkg::SLOT_CTRL] = s1.write_data & bdcr_pkg::CTRL_KEEP;
          if (start) begin
            row_next[bdcr_pkg::SLOT_STATUS] =
              (row[bdcr_pkg::SLOT_STATUS] & ~bdcr_pkg::ST_BUSY) | bdcr_pkg::ST_SET;
          end
        end
        bdcr_pkg::SLOT_STATUS: begin
          row_next[bdcr_pkg::SLOT_STATUS] =
            row[bdcr_pkg::SLOT_STATUS] & ~(s1.write_data & bdcr_pkg::ST_W1C_MASK);
        end
        default: begin
          if (!is_plain) begin
            row_next[s1.reg_index] = s1.write_data;
          end
        end
      endcase
    end
    res_next.copy_start = start;
    res_next.bad_port   = trigger && !start;
    if (start) begin
      res_next.copy_source = src_map.phys;
      res_next.copy_dest   = dst_map.phys;
      res_next.copy_bytes  = {row[bdcr_pkg::SLOT_SIZE_HI], row[bdcr_pkg::SLOT_SIZE_LO]};
    end
  end

  // channel register storage update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < EFF_CH; c++) begin
        special[c] <= '0;
        for (int p = 0; p < PLAIN_DEPTH; p++) begin
          plain[c][p] <= '0;
        end
      end
    end else if (adv && in_range && is_write) begin
      if (is_plain) begin
        plain[ch_idx][pidx] <= s1.write_data;
      end else begin
        special[ch_idx] <= row_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.read_data   = res.read_data;
  assign result.copy_start  = res.copy_start;
  assign result.copy_source = res.copy_source;
  assign result.copy_dest   = res.copy_dest;
  assign result.copy_bytes  = res.copy_bytes;
  assign result.bad_port    = res.bad_port;

  // checks
  `ASSERT_ALWAYS(a_start_not_bad, !(out_valid && result.copy_start && result.bad_port))
  `ASSERT_IMPLY(a_stall_only_when_full, !access.ready,
                s1_valid && out_valid && !result.ready)
  `ASSERT_NEXT(a_status_set_on_start, adv && start,
               (special[$past(ch_idx)][bdcr_pkg::SLOT_STATUS] & bdcr_pkg::ST_SET) ==
               bdcr_pkg::ST_SET)

  for (genvar c = 0; c < EFF_CH; c++) begin : g_chk
    `ASSERT_ALWAYS(a_trigger_not_stored, special[c][bdcr_pkg::SLOT_CTRL][0] == 1'b0)
  end

endmodule

`default_nettype wire

// ===== tb/tb_byte_dma_channel_registers_unit.sv =====
`timescale 1ns / 1ps

module tb_byte_dma_channel_registers_unit;

  localparam int CHANNELS          = 2;
  localparam int REGS_PER_CHANNEL  = 16;
  localparam int FLASH_WINDOW_LOG2 = 24;

  // results that can be read off at a glance
  localparam bdcr_pkg::bdcr_result_t RESULT_IDLE     = '0;
  localparam bdcr_pkg::bdcr_result_t RESULT_BAD_PORT = '{bad_port: 1'b1, default: '0};
  localparam bdcr_pkg::bdcr_result_t RESULT_ONES     = '{read_data: 16'hffff, default: '0};

  typedef struct {
    bdcr_pkg::bdcr_item_t   access;
    logic                   pinned;
    bdcr_pkg::bdcr_result_t result;
  } directed_row_t;

  // directed accesses: reset values, extremes, zero length, flash window, bad ports
  directed_row_t directed_rows [25] = '{
    '{'{bdcr_pkg::MODE_READ,  1'b0, bdcr_pkg::SLOT_CTRL,    16'h0000}, 1'b1, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_READ,  1'b1, 4'd15,                  16'hffff}, 1'b1, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, 4'd15,                  16'hffff}, 1'b1, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_READ,  1'b0, 4'd15,                  16'h0000}, 1'b1, RESULT_ONES},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_CONFIG,  16'h0500}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_SRC_LO,  16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_SRC_HI,  16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_DST_LO,  16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_DST_HI,  16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_CTRL,    16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_READ,  1'b0, bdcr_pkg::SLOT_STATUS,  16'h0000}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_READ,  1'b0, bdcr_pkg::SLOT_CTRL,    16'h0000}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_SIZE_LO, 16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_SIZE_HI, 16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_MISC,    16'h3000}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_CONFIG,  16'h0105}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_CTRL,    16'h0001}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_STATUS,  16'h0004}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_READ,  1'b0, bdcr_pkg::SLOT_STATUS,  16'h0000}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b0, bdcr_pkg::SLOT_STATUS,  16'hffff}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b1, bdcr_pkg::SLOT_CONFIG,  16'h0f00}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b1, bdcr_pkg::SLOT_CTRL,    16'h0001}, 1'b1, RESULT_BAD_PORT},
    '{'{bdcr_pkg::MODE_WRITE, 1'b1, bdcr_pkg::SLOT_CONFIG,  16'h0002}, 1'b0, RESULT_IDLE},
    '{'{bdcr_pkg::MODE_WRITE, 1'b1, bdcr_pkg::SLOT_CTRL,    16'hffff}, 1'b1, RESULT_BAD_PORT},
    '{'{bdcr_pkg::MODE_READ,  1'b1, bdcr_pkg::SLOT_STATUS,  16'h0000}, 1'b1, RESULT_IDLE}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [bdcr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // fixed expectation travelling with the access being driven
  logic                   pin_valid;
  bdcr_pkg::bdcr_result_t pin_result;

  bdcr_in_if  access_if ();
  bdcr_out_if result_if ();

  byte_dma_channel_registers_unit #(
    .CHANNELS          (CHANNELS),
    .REGS_PER_CHANNEL  (REGS_PER_CHANNEL),
    .FLASH_WINDOW_LOG2 (FLASH_WINDOW_LOG2)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .access    (access_if),
    .result    (result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the channel registers and translation bases
  logic [15:0] shadow_regs [CHANNELS][REGS_PER_CHANNEL];
  logic [31:0] shadow_dram_base;
  logic [31:0] shadow_sram_base;
  logic [31:0] shadow_flash_base;

  bdcr_pkg::bdcr_result_t pending_responses [$];
  int errors        = 0;
  int accesses_sent = 0;
  int copies_seen   = 0;
  int bad_seen      = 0;
  int base_settings = 1;
  logic quiet_stretch = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // port to physical address, ok is low for an unknown port
  function automatic logic translate_port(input logic [3:0] port, input logic [1:0] sel,
                                          input logic [31:0] addr,
                                          output logic [31:0] phys);
    logic [31:0] window_mask;
    window_mask = (32'd1 << FLASH_WINDOW_LOG2) - 32'd1;
    phys = '0;
    if (port == bdcr_pkg::PORT_MEM0 || port == bdcr_pkg::PORT_MEM1) begin
      phys = ((sel == bdcr_pkg::SEL_SRAM) ? shadow_sram_base : shadow_dram_base) + addr;
      return 1'b1;
    end
    if (port == bdcr_pkg::PORT_FLASH) begin
      phys = shadow_flash_base + (addr & window_mask);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one bus access to the shadow registers and return its result
  function automatic bdcr_pkg::bdcr_result_t apply_access(input bdcr_pkg::bdcr_item_t acc);
    bdcr_pkg::bdcr_result_t res;
    logic [15:0] cfg_slot;
    logic [1:0]  sel;
    logic [31:0] src_phys, dst_phys;
    logic        src_ok, dst_ok;
    res = '0;
    if (acc.mode == bdcr_pkg::MODE_READ) begin
      res.read_data = shadow_regs[acc.channel][acc.reg_index];
    end else begin
      case (acc.reg_index)
        bdcr_pkg::SLOT_CTRL: begin
          shadow_regs[acc.channel][bdcr_pkg::SLOT_CTRL] = acc.write_data & bdcr_pkg::CTRL_KEEP;
          if (acc.write_data[0]) begin
            cfg_slot = shadow_regs[acc.channel][bdcr_pkg::SLOT_CONFIG];
            sel      = shadow_regs[acc.channel][bdcr_pkg::SLOT_MISC][13:12];
            src_ok = translate_port(cfg_slot[3:0], sel,
                                    {shadow_regs[acc.channel][bdcr_pkg::SLOT_SRC_HI],
                                     shadow_regs[acc.channel][bdcr_pkg::SLOT_SRC_LO]},
                                    src_phys);
            dst_ok = translate_port(cfg_slot[11:8], sel,
                                    {shadow_regs[acc.channel][bdcr_pkg::SLOT_DST_HI],
                                     shadow_regs[acc.channel][bdcr_pkg::SLOT_DST_LO]},
                                    dst_phys);
            if (src_ok && dst_ok) begin
              res.copy_start  = 1'b1;
              res.copy_source = src_phys;
              res.copy_dest   = dst_phys;
              res.copy_bytes  = {shadow_regs[acc.channel][bdcr_pkg::SLOT_SIZE_HI],
                                 shadow_regs[acc.channel][bdcr_pkg::SLOT_SIZE_LO]};
              shadow_regs[acc.channel][bdcr_pkg::SLOT_STATUS] =
                (shadow_regs[acc.channel][bdcr_pkg::SLOT_STATUS] & ~bdcr_pkg::ST_BUSY) |
                bdcr_pkg::ST_SET;
            end else begin
              res.bad_port = 1'b1;
            end
          end
        end
        bdcr_pkg::SLOT_STATUS: begin
          shadow_regs[acc.channel][bdcr_pkg::SLOT_STATUS] &=
            ~(acc.write_data & bdcr_pkg::ST_W1C_MASK);
        end
        default: begin
          shadow_regs[acc.channel][acc.reg_index] = acc.write_data;
        end
      endcase
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // predict on each accepted access, check each accepted result in order
  always @(posedge clk) begin : scoreboard
    bdcr_pkg::bdcr_item_t   acc;
    bdcr_pkg::bdcr_result_t predicted;
    bdcr_pkg::bdcr_result_t want;
    if (!rst) begin
      if (access_if.valid && access_if.ready) begin
        acc = '{mode: access_if.mode, channel: access_if.channel,
                reg_index: access_if.reg_index, write_data: access_if.write_data};
        predicted = apply_access(acc);
        pending_responses.push_back(pin_valid ? pin_result : predicted);
      end
      if (result_if.valid && result_if.ready) begin
        if (pending_responses.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = pending_responses.pop_front();
          compare_field("read_data",   result_if.read_data,   want.read_data);
          compare_field("copy_start",  result_if.copy_start,  want.copy_start);
          compare_field("copy_source", result_if.copy_source, want.copy_source);
          compare_field("copy_dest",   result_if.copy_dest,   want.copy_dest);
          compare_field("copy_bytes",  result_if.copy_bytes,  want.copy_bytes);
          compare_field("bad_port",    result_if.bad_port,    want.bad_port);
          if (want.copy_start) copies_seen++;
          if (want.bad_port) bad_seen++;
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    result_if.ready <= quiet_stretch || ($urandom_range(99) >= 6);
  end

  // one access transfer, sometimes with valid held low before it unless quiet_stretch is set
  task automatic send_access(input bdcr_pkg::bdcr_item_t acc, input logic pinned = 1'b0,
                             input bdcr_pkg::bdcr_result_t pinned_res = '0);
    if (!quiet_stretch && $urandom_range(99) < 6) begin
      access_if.valid <= 1'b0;
      @(posedge clk);
    end
    access_if.valid      <= 1'b1;
    access_if.mode       <= acc.mode;
    access_if.channel    <= acc.channel;
    access_if.reg_index  <= acc.reg_index;
    access_if.write_data <= acc.write_data;
    pin_valid            <= pinned;
    pin_result           <= pinned_res;
    do @(posedge clk); while (!access_if.ready);
    accesses_sent++;
  endtask

  // stop sending and let every pending result come back
  task automatic drain_results();
    access_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [bdcr_pkg::CFG_INDEX_W-1:0] index,
                            input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      bdcr_pkg::CFG_DRAM_BASE:  shadow_dram_base  = value;
      bdcr_pkg::CFG_SRAM_BASE:  shadow_sram_base  = value;
      bdcr_pkg::CFG_FLASH_BASE: shadow_flash_base = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_bases(input logic [31:0] dram, input logic [31:0] sram,
                           input logic [31:0] flash);
    drain_results();
    write_base(bdcr_pkg::CFG_DRAM_BASE, dram);
    write_base(bdcr_pkg::CFG_SRAM_BASE, sram);
    write_base(bdcr_pkg::CFG_FLASH_BASE, flash);
    base_settings++;
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly known ports, sometimes an arbitrary code
  function automatic logic [3:0] pick_port();
    case ($urandom_range(9))
      0, 1, 2: return bdcr_pkg::PORT_MEM0;
      3, 4, 5: return bdcr_pkg::PORT_MEM1;
      6, 7, 8: return bdcr_pkg::PORT_FLASH;
      default: return 4'($urandom);
    endcase
  endfunction

  function automatic bdcr_pkg::bdcr_item_t random_access();
    return '{mode: 1'($urandom), channel: 1'($urandom),
             reg_index: 4'($urandom), write_data: pick_half()};
  endfunction

  task automatic write_slot(input logic ch, input logic [3:0] slot, input logic [15:0] data);
    send_access('{mode: bdcr_pkg::MODE_WRITE, channel: ch, reg_index: slot, write_data: data});
  endtask

  // program a channel and trigger a copy, then look at or clear status
  task automatic copy_sequence();
    logic        ch;
    logic [15:0] data;
    ch = 1'($urandom);
    data = 16'($urandom);
    data[3:0]  = pick_port();
    data[11:8] = pick_port();
    write_slot(ch, bdcr_pkg::SLOT_CONFIG, data);
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_MISC, 16'($urandom));
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_SRC_LO, pick_half());
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_SRC_HI, pick_half());
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_DST_LO, pick_half());
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_DST_HI, pick_half());
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_SIZE_LO, pick_half());
    if ($urandom_range(3) != 0) write_slot(ch, bdcr_pkg::SLOT_SIZE_HI, pick_half());
    write_slot(ch, bdcr_pkg::SLOT_CTRL, 16'($urandom) | 16'h0001);
    if ($urandom_range(1) != 0)
      send_access('{mode: bdcr_pkg::MODE_READ, channel: ch,
                    reg_index: bdcr_pkg::SLOT_STATUS, write_data: 16'($urandom)});
    if ($urandom_range(1) != 0) write_slot(ch, bdcr_pkg::SLOT_STATUS, pick_half());
  endtask

  task automatic random_phase(input int count, input logic with_pause);
    int stop_at;
    int pause_at;
    stop_at  = accesses_sent + count;
    pause_at = accesses_sent + count / 2;
    while (accesses_sent < stop_at) begin
      if ($urandom_range(9) < 7) copy_sequence();
      else send_access(random_access());
      if (with_pause && accesses_sent >= pause_at) begin
        drain_results();
        pause_at = stop_at + 1;
      end
    end
  endtask

  // watchdog
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst                  <= 1'b1;
    cfg_write            <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    access_if.valid      <= 1'b0;
    access_if.mode       <= bdcr_pkg::MODE_READ;
    access_if.channel    <= 1'b0;
    access_if.reg_index  <= '0;
    access_if.write_data <= '0;
    pin_valid            <= 1'b0;
    pin_result           <= '0;
    foreach (shadow_regs[c, s]) shadow_regs[c][s] = '0;
    shadow_dram_base  = '0;
    shadow_sram_base  = '0;
    shadow_flash_base = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table with reset bases
    foreach (directed_rows[i])
      send_access(directed_rows[i].access, directed_rows[i].pinned, directed_rows[i].result);

    // random phases over several base settings
    set_bases(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    random_phase(160, 1'b0);
    set_bases($urandom, $urandom, $urandom);
    random_phase(160, 1'b1);
    set_bases('0, '0, '0);
    quiet_stretch = 1'b1;
    random_phase(160, 1'b0);
    quiet_stretch = 1'b0;
    set_bases($urandom, $urandom, 32'hff00_0000);
    random_phase(170, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_responses.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_responses.size()));

    $display("covered %0d bus accesses under %0d base settings", accesses_sent, base_settings);
    $display("%0d copy commands and %0d bad-port triggers checked", copies_seen, bad_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
